FILE: sv/mdas_pkg.sv
package mdas_pkg;

	localparam int MAX_DIMS   = 4;
	localparam int EXT_FIELDS = 4;
	localparam int DIM_LIMIT  = (MAX_DIMS < EXT_FIELDS) ? MAX_DIMS : EXT_FIELDS;
	localparam int DIM_W      = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;
	localparam int CAPACITY   = 4096;
	localparam int OFF_W      = $clog2(CAPACITY);

	localparam int DIMS_W    = 3;
	localparam int EXT_W     = 13;
	localparam int IDX_W     = 12;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int EOFF_W    = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 13;

	localparam int PROD_W = OFF_W + EXT_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_3 = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INDEX    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_MEM,
		ST_OUT
	} state_t;

endpackage

FILE: sv/multidim_array_store.sv
// Flow: an accepted transaction passes through ST_STEP, one dimension per cycle over the
// dimensions in use through a shared multiply-add, then ST_MEM for the element memory access
// and ST_OUT for the output load; an index or capacity error goes from ST_STEP straight to
// ST_OUT. Input stalls while an item is in flight, so a new item is taken only after the
// last one has left ST_OUT.
// Offset is formed as ((i0 * e1 + i1) * e2 + i2) ..., equal to the sum of stride times index.
// Reset: asynchronous, active low; dimensions and extents return to 1, output empty,
// element memory keeps its contents (undefined until written).
module multidim_array_store (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mdas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mdas_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [mdas_pkg::IDX_W-1:0]           index_0,
	input  logic [mdas_pkg::IDX_W-1:0]           index_1,
	input  logic [mdas_pkg::IDX_W-1:0]           index_2,
	input  logic [mdas_pkg::IDX_W-1:0]           index_3,
	input  logic signed [mdas_pkg::DATA_W-1:0]   write_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [mdas_pkg::DATA_W-1:0]   read_value,
	output logic [mdas_pkg::STATUS_W-1:0]        status,
	output logic [mdas_pkg::EOFF_W-1:0]          element_offset
);

	mdas_pkg::state_t state_q, state_d;

	logic [mdas_pkg::DIMS_W-1:0] dims_q;
	logic [mdas_pkg::EXT_W-1:0]  ext_q [mdas_pkg::EXT_FIELDS];

	logic [mdas_pkg::IDX_W-1:0]  idx_q [mdas_pkg::EXT_FIELDS];
	logic                        write_q;
	logic [mdas_pkg::DATA_W-1:0] wdata_q;
	logic [mdas_pkg::DIM_W-1:0]  k_q;
	logic [mdas_pkg::OFF_W-1:0]  acc_q;
	logic                        ovf_q;
	logic [mdas_pkg::STATUS_W-1:0] stat_q;

	logic [mdas_pkg::DATA_W-1:0] mem [mdas_pkg::CAPACITY];
	logic [mdas_pkg::DATA_W-1:0] rdata_q;

	logic                          out_valid_q;
	logic [mdas_pkg::DATA_W-1:0]   rv_q;
	logic [mdas_pkg::STATUS_W-1:0] st_q;
	logic [mdas_pkg::OFF_W-1:0]    off_q;

	logic                        in_take;
	logic                        out_free;
	logic [mdas_pkg::DIMS_W-1:0] used_dims;
	logic [mdas_pkg::DIM_W-1:0]  last_k;
	logic [mdas_pkg::IDX_W-1:0]  ix_sel;
	logic [mdas_pkg::EXT_W-1:0]  ext_sel;
	logic                        idx_bad;
	logic [mdas_pkg::PROD_W-1:0] prod;
	logic [mdas_pkg::SUM_W-1:0]  sum;
	logic                        big;
	logic                        is_last;

	// clamp the dimension count to the supported range
	always_comb begin
		priority if (dims_q == '0) begin
			used_dims = mdas_pkg::DIMS_W'(1);
		end else if (dims_q > mdas_pkg::DIMS_W'(mdas_pkg::DIM_LIMIT)) begin
			used_dims = mdas_pkg::DIMS_W'(mdas_pkg::DIM_LIMIT);
		end else begin
			used_dims = dims_q;
		end
	end

	assign last_k = mdas_pkg::DIM_W'(used_dims - mdas_pkg::DIMS_W'(1));

	// shared multiply-add for one dimension
	assign ix_sel  = idx_q[k_q];
	assign ext_sel = ext_q[k_q];
	assign idx_bad = {1'b0, ix_sel} >= ext_sel;
	assign prod    = mdas_pkg::PROD_W'(acc_q) * mdas_pkg::PROD_W'(ext_sel);
	assign sum     = mdas_pkg::SUM_W'(prod) + mdas_pkg::SUM_W'(ix_sel);
	assign big     = sum >= mdas_pkg::SUM_W'(mdas_pkg::CAPACITY);
	assign is_last = k_q == last_k;

	assign out_free = !out_valid_q || !out_stall;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mdas_pkg::ST_IDLE: begin
				if (in_valid) state_d = mdas_pkg::ST_STEP;
			end
			mdas_pkg::ST_STEP: begin
				priority if (idx_bad) begin
					state_d = mdas_pkg::ST_OUT;
				end else if (is_last) begin
					state_d = (ovf_q || big) ? mdas_pkg::ST_OUT : mdas_pkg::ST_MEM;
				end else begin
					state_d = mdas_pkg::ST_STEP;
				end
			end
			mdas_pkg::ST_MEM: begin
				state_d = mdas_pkg::ST_OUT;
			end
			mdas_pkg::ST_OUT: begin
				if (out_free) state_d = mdas_pkg::ST_IDLE;
			end
			default: state_d = mdas_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != mdas_pkg::ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdas_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= mdas_pkg::DIMS_W'(1);
			for (int i = 0; i < mdas_pkg::EXT_FIELDS; i++) begin
				ext_q[i] <= mdas_pkg::EXT_W'(1);
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				mdas_pkg::REG_DIMS:  dims_q   <= cfg_data[mdas_pkg::DIMS_W-1:0];
				mdas_pkg::REG_EXT_0: ext_q[0] <= cfg_data;
				mdas_pkg::REG_EXT_1: ext_q[1] <= cfg_data;
				mdas_pkg::REG_EXT_2: ext_q[2] <= cfg_data;
				mdas_pkg::REG_EXT_3: ext_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// item registers and the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			ovf_q  <= 1'b0;
			stat_q <= mdas_pkg::STATUS_OK;
		end else if (in_take) begin
			k_q    <= '0;
			ovf_q  <= 1'b0;
			stat_q <= mdas_pkg::STATUS_OK;
		end else if (state_q == mdas_pkg::ST_STEP) begin
			priority if (idx_bad) begin
				stat_q <= mdas_pkg::STATUS_INDEX;
			end else begin
				ovf_q <= ovf_q || big;
				k_q   <= mdas_pkg::DIM_W'(k_q + mdas_pkg::DIM_W'(1));
				if (is_last && (ovf_q || big)) stat_q <= mdas_pkg::STATUS_CAPACITY;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			idx_q[0] <= index_0;
			idx_q[1] <= index_1;
			idx_q[2] <= index_2;
			idx_q[3] <= index_3;
			write_q  <= action;
			wdata_q  <= write_value;
			acc_q    <= '0;
		end else if (state_q == mdas_pkg::ST_STEP && !idx_bad) begin
			acc_q <= sum[mdas_pkg::OFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mdas_pkg::ST_MEM) begin
			if (write_q) mem[acc_q] <= wdata_q;
			rdata_q <= mem[acc_q];
		end
	end

	// output register: load when the previous transaction has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == mdas_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mdas_pkg::ST_OUT && out_free) begin
			st_q  <= stat_q;
			off_q <= (stat_q == mdas_pkg::STATUS_OK) ? acc_q : '0;
			rv_q  <= (stat_q == mdas_pkg::STATUS_OK && !write_q) ? rdata_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = rv_q;
	assign status         = st_q;
	assign element_offset = mdas_pkg::EOFF_W'(off_q);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mdas_pkg::STATUS_OK |-> element_offset == '0 && read_value == '0)
		else $error("error result carries a nonzero offset or value");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == mdas_pkg::ST_STEP && k_q == '0 && !ovf_q)
		else $error("accepted transaction did not start the iteration cleanly");

	a_mem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mdas_pkg::ST_MEM |-> stat_q == mdas_pkg::STATUS_OK && !ovf_q)
		else $error("memory access on a failed transaction");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == mdas_pkg::STATUS_OK || status == mdas_pkg::STATUS_INDEX ||
			status == mdas_pkg::STATUS_CAPACITY)
		else $error("undefined status code");

endmodule

FILE: tb/sv/multidim_array_store_tb.sv
`timescale 1ns / 1ps

module multidim_array_store_tb;
	import mdas_pkg::*;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	// first register index with nothing behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int CALM_PHASE      = 5;
	localparam int DRAIN_CYCLES    = 16;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int LANDED_DEPTH    = 64;

	typedef logic [3:0][IDX_W-1:0] coord_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [STATUS_W-1:0]      code;
		logic [EOFF_W-1:0]        offset;
	} answer_t;

	typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]    reg_val;
		logic                act;
		coord_t              at;
		logic [DATA_W-1:0]   value;
		bit                  typed;
		answer_t             want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [IDX_W-1:0] index_0 = '0;
	logic [IDX_W-1:0] index_1 = '0;
	logic [IDX_W-1:0] index_2 = '0;
	logic [IDX_W-1:0] index_3 = '0;
	logic signed [DATA_W-1:0] write_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] read_value;
	logic [STATUS_W-1:0] status;
	logic [EOFF_W-1:0] element_offset;

	multidim_array_store dut (.*);

	// mirror of the block's registers and element store
	logic [DIMS_W-1:0] dims_mirror;
	logic [EXT_W-1:0]  ext_mirror [4];
	logic [31:0]       stride_mirror [4];
	logic [DATA_W-1:0] element_mirror [CAPACITY];
	bit                filled [CAPACITY];
	coord_t            landed [$];

	answer_t     expected_answers [$];
	script_row_t script [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          calm = 1'b0;

	initial forever #6 clk = ~clk;

	function automatic int used_count();
		int d;
		d = dims_mirror;
		if (d < 1) d = 1;
		if (d > DIM_LIMIT) d = DIM_LIMIT;
		return d;
	endfunction

	function automatic void rederive_strides();
		int d;
		logic [63:0] run;
		d = used_count();
		run = 64'd1;
		for (int k = 0; k < 4; k++) stride_mirror[k] = '0;
		stride_mirror[d-1] = 32'd1;
		for (int k = d - 1; k > 0; k--) begin
			run = run * ext_mirror[k];
			if (run > 64'hFFFF_FFFF) run = 64'hFFFF_FFFF;
			stride_mirror[k-1] = run[31:0];
		end
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		case (idx)
			REG_DIMS:  dims_mirror = val[DIMS_W-1:0];
			REG_EXT_0: ext_mirror[0] = val;
			REG_EXT_1: ext_mirror[1] = val;
			REG_EXT_2: ext_mirror[2] = val;
			REG_EXT_3: ext_mirror[3] = val;
			default: ;
		endcase
		rederive_strides();
		landed.delete();
	endfunction

	// index check first, then capacity; offset is zero on any error
	function automatic void locate(input coord_t at, output logic [STATUS_W-1:0] code,
			output logic [63:0] offset);
		int d;
		d = used_count();
		code = STATUS_OK;
		offset = '0;
		for (int k = 0; k < d && code == STATUS_OK; k++) begin
			if ({1'b0, at[k]} >= ext_mirror[k]) code = STATUS_INDEX;
			else offset = offset + stride_mirror[k] * at[k];
		end
		if (code == STATUS_OK && offset >= CAPACITY) code = STATUS_CAPACITY;
		if (code != STATUS_OK) offset = '0;
	endfunction

	function automatic answer_t apply_transaction(input logic act, input coord_t at,
			input logic [DATA_W-1:0] value);
		answer_t ans;
		logic [STATUS_W-1:0] code;
		logic [63:0] offset;
		locate(at, code, offset);
		ans.value = '0;
		ans.code = code;
		ans.offset = offset[EOFF_W-1:0];
		if (code == STATUS_OK) begin
			if (act == ACT_WRITE) begin
				element_mirror[offset[OFF_W-1:0]] = value;
				filled[offset[OFF_W-1:0]] = 1'b1;
				landed.push_back(at);
				if (landed.size() > LANDED_DEPTH) void'(landed.pop_front());
			end else begin
				ans.value = element_mirror[offset[OFF_W-1:0]];
			end
		end
		return ans;
	endfunction

	function automatic coord_t spot(input int i0, input int i1, input int i2, input int i3);
		return {IDX_W'(i3), IDX_W'(i2), IDX_W'(i1), IDX_W'(i0)};
	endfunction

	function automatic answer_t answer(input logic [STATUS_W-1:0] code, input int offset,
			input logic [DATA_W-1:0] value);
		answer_t ans;
		ans.value = value;
		ans.code = code;
		ans.offset = EOFF_W'(offset);
		return ans;
	endfunction

	function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		script_row_t r;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		r.act = ACT_READ;
		r.at = '0;
		r.value = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic script_row_t item_row(input logic act, input coord_t at,
			input logic [DATA_W-1:0] value);
		script_row_t r;
		r = reg_row(REG_DIMS, '0);
		r.kind = ROW_ITEM;
		r.act = act;
		r.at = at;
		r.value = value;
		return r;
	endfunction

	function automatic script_row_t known_row(input logic act, input coord_t at,
			input logic [DATA_W-1:0] value, input answer_t want);
		script_row_t r;
		r = item_row(act, at, value);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] inside_extent(input logic [EXT_W-1:0] ext);
		int hi;
		if (ext == '0) return IDX_W'($urandom);
		hi = ext - 1;
		if (hi > 4095) hi = 4095;
		return IDX_W'($urandom_range(hi));
	endfunction

	function automatic void make_item(output logic act, output coord_t at,
			output logic [DATA_W-1:0] value);
		int d;
		int pick;
		logic [STATUS_W-1:0] code;
		logic [63:0] offset;
		logic [EXT_W-1:0] ext;
		d = used_count();
		pick = $urandom_range(99);
		for (int k = 0; k < 4; k++) begin
			ext = ext_mirror[k];
			if (k >= d || (pick >= 60 && pick < 80)) at[k] = IDX_W'($urandom);
			else if (pick < 60) at[k] = inside_extent(ext);
			else begin
				case ($urandom_range(3))
					0: at[k] = IDX_W'(ext - 1);
					1: at[k] = IDX_W'(ext);
					2: at[k] = '0;
					default: at[k] = '1;
				endcase
			end
		end
		value = $urandom;
		act = logic'($urandom_range(1));
		if (act == ACT_READ && landed.size() != 0 && $urandom_range(99) < 60)
			at = landed[$urandom_range(landed.size() - 1)];
		// never read an element that has not been written
		locate(at, code, offset);
		if (act == ACT_READ && code == STATUS_OK && !filled[offset[OFF_W-1:0]])
			act = ACT_WRITE;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_register(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_item(input logic act, input coord_t at, input logic [DATA_W-1:0] value,
			input bit typed, input answer_t want);
		answer_t forecast;
		while (!calm && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		index_0 <= at[0];
		index_1 <= at[1];
		index_2 <= at[2];
		index_3 <= at[3];
		write_value <= value;
		do @(posedge clk); while (in_stall);
		forecast = apply_transaction(act, at, value);
		expected_answers.push_back(typed ? want : forecast);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_answers.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure_phase(input int p);
		int d;
		int lim;
		bit wild;
		logic [CFG_W-1:0] dims_val;
		logic [CFG_W-1:0] ext [4];
		logic [CFG_IDX_W-1:0] spare;
		dims_val = CFG_W'($urandom_range(7));
		wild = ($urandom_range(3) == 0);
		d = (dims_val < 1) ? 1 : (dims_val > DIM_LIMIT) ? DIM_LIMIT : int'(dims_val);
		lim = (d == 1) ? 4096 : (d == 2) ? 64 : (d == 3) ? 16 : 8;
		// allow some overshoot so the capacity check fires now and then
		for (int k = 0; k < 4; k++) begin
			if (!wild) ext[k] = CFG_W'($urandom_range(lim + lim / 2, 1));
			else if ($urandom_range(5) == 0) ext[k] = '0;
			else ext[k] = CFG_W'($urandom_range(8191));
		end
		if (p == 0) begin
			dims_val = 1;
			ext[0] = 4096;
		end else if (p == 1) begin
			dims_val = 4;
			for (int k = 0; k < 4; k++) ext[k] = 8;
		end else if (p == 2) begin
			dims_val = 2;
			ext[0] = 64;
			ext[1] = 64;
		end else if (p == PHASES - 1) begin
			dims_val = 4;
			for (int k = 0; k < 4; k++) ext[k] = '1;
		end
		spare = REG_SPARE + CFG_IDX_W'($urandom_range(2));
		set_register(REG_DIMS, dims_val);
		set_register(REG_EXT_0, ext[0]);
		set_register(REG_EXT_1, ext[1]);
		set_register(REG_EXT_2, ext[2]);
		set_register(REG_EXT_3, ext[3]);
		set_register(spare, CFG_W'($urandom_range(8191)));
	endtask

	always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 25);

	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_answers.size() == 0) begin
				flag_mismatch("result with no transaction pending");
			end else begin
				want = expected_answers.pop_front();
				if (read_value !== want.value)
					flag_mismatch($sformatf("read_value %0d, expected %0d",
						read_value, want.value));
				if (status !== want.code)
					flag_mismatch($sformatf("status %0d, expected %0d", status, want.code));
				if (element_offset !== want.offset)
					flag_mismatch($sformatf("element_offset %0d, expected %0d",
						element_offset, want.offset));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("FAIL multidim_array_store");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic act;
		coord_t at;
		logic [DATA_W-1:0] value;

		dims_mirror = 1;
		for (int k = 0; k < 4; k++) ext_mirror[k] = 1;
		rederive_strides();

		// reset shape: one dimension of extent one
		script.push_back(known_row(ACT_WRITE, spot(0, 0, 0, 0), 32'h7FFF_FFFF,
			answer(STATUS_OK, 0, 0)));
		script.push_back(known_row(ACT_READ, spot(0, 4095, 4095, 4095), 0,
			answer(STATUS_OK, 0, 32'h7FFF_FFFF)));
		script.push_back(known_row(ACT_WRITE, spot(1, 0, 0, 0), $urandom,
			answer(STATUS_INDEX, 0, 0)));
		script.push_back(known_row(ACT_READ, spot(4095, 0, 0, 0), 0,
			answer(STATUS_INDEX, 0, 0)));
		// four dimensions of eight fill the store exactly
		script.push_back(reg_row(REG_DIMS, 4));
		script.push_back(reg_row(REG_EXT_0, 8));
		script.push_back(reg_row(REG_EXT_1, 8));
		script.push_back(reg_row(REG_EXT_2, 8));
		script.push_back(reg_row(REG_EXT_3, 8));
		script.push_back(known_row(ACT_WRITE, spot(7, 7, 7, 7), 32'h8000_0000,
			answer(STATUS_OK, 4095, 0)));
		script.push_back(known_row(ACT_READ, spot(7, 7, 7, 7), 0,
			answer(STATUS_OK, 4095, 32'h8000_0000)));
		script.push_back(known_row(ACT_WRITE, spot(0, 0, 0, 8), $urandom,
			answer(STATUS_INDEX, 0, 0)));
		script.push_back(known_row(ACT_WRITE, spot(8, 0, 0, 0), $urandom,
			answer(STATUS_INDEX, 0, 0)));
		script.push_back(item_row(ACT_WRITE, spot(1, 2, 3, 4), $urandom));
		script.push_back(item_row(ACT_READ, spot(1, 2, 3, 4), 0));
		// a zero extent rejects every index
		script.push_back(reg_row(REG_EXT_1, 0));
		script.push_back(known_row(ACT_READ, spot(0, 0, 0, 0), 0,
			answer(STATUS_INDEX, 0, 0)));
		// twice the capacity
		script.push_back(reg_row(REG_EXT_1, 16));
		script.push_back(known_row(ACT_WRITE, spot(7, 15, 7, 7), $urandom,
			answer(STATUS_CAPACITY, 0, 0)));
		script.push_back(known_row(ACT_WRITE, spot(4, 0, 0, 0), $urandom,
			answer(STATUS_CAPACITY, 0, 0)));
		script.push_back(known_row(ACT_WRITE, spot(3, 15, 7, 7), $urandom,
			answer(STATUS_OK, 4095, 0)));
		// zero dimensions count as one; extent wider than the index
		script.push_back(reg_row(REG_DIMS, 0));
		script.push_back(reg_row(REG_EXT_0, 8191));
		script.push_back(known_row(ACT_WRITE, spot(4095, 4095, 4095, 4095), 32'hA5A5_5A5A,
			answer(STATUS_OK, 4095, 0)));
		script.push_back(item_row(ACT_READ, spot(4095, 0, 0, 0), 0));
		// dimension count above the limit clamps to four
		script.push_back(reg_row(REG_DIMS, 13'h1FFF));
		script.push_back(known_row(ACT_WRITE, spot(4095, 0, 0, 0), $urandom,
			answer(STATUS_CAPACITY, 0, 0)));
		script.push_back(known_row(ACT_WRITE, spot(0, 0, 0, 4095), $urandom,
			answer(STATUS_INDEX, 0, 0)));
		script.push_back(reg_row(REG_EXT_3, 8191));
		script.push_back(reg_row(REG_EXT_2, 8191));
		script.push_back(known_row(ACT_WRITE, spot(0, 0, 1, 0), $urandom,
			answer(STATUS_CAPACITY, 0, 0)));
		script.push_back(known_row(ACT_WRITE, spot(0, 0, 0, 4095), $urandom,
			answer(STATUS_OK, 4095, 0)));
		script.push_back(item_row(ACT_READ, spot(0, 0, 0, 4095), 0));
		script.push_back(reg_row(REG_SPARE, 0));
		script.push_back(item_row(ACT_READ, spot(0, 0, 0, 4095), 0));
		// outer stride saturates beyond 32 bits
		script.push_back(reg_row(REG_EXT_1, 8191));
		script.push_back(known_row(ACT_WRITE, spot(1, 0, 0, 0), $urandom,
			answer(STATUS_CAPACITY, 0, 0)));
		script.push_back(known_row(ACT_WRITE, spot(0, 0, 0, 5), 32'hFFFF_FFFF,
			answer(STATUS_OK, 5, 0)));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_REG) begin
				wait_idle();
				set_register(script[r].reg_idx, script[r].reg_val);
			end else begin
				send_item(script[r].act, script[r].at, script[r].value,
					script[r].typed, script[r].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			configure_phase(p);
			calm = (p == CALM_PHASE);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				make_item(act, at, value);
				send_item(act, at, value, 1'b0, '0);
			end
		end
		calm = 1'b0;

		wait_idle();
		if (mismatches == 0 && expected_answers.size() == 0) begin
			$display("PASS multidim_array_store");
		end else begin
			$display("FAIL multidim_array_store");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/mdas_pkg.sv
sv/multidim_array_store.sv
tb/sv/multidim_array_store_tb.sv
